### design/sif_pkg.sv
package sif_pkg;

  localparam int SAMPLE_W  = 32;
  localparam int RESULT_W  = 64;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 1;
  localparam int LIMBS     = 4;
  localparam int LIMB_W    = 32;
  localparam int QUO_W     = (LIMBS - 1) * LIMB_W;
  localparam int DIV_BITS  = 16;
  localparam int DIV_STEPS = QUO_W / DIV_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int CHUNK_W   = DIV_BITS + 2;
  localparam int RECIP_SH  = 19;
  localparam int PRE_SHIFT = 3;
  localparam int MIN_RUN   = 3;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QFILL_W   = $clog2(QDEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_SPACING      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RESULT_SCALE = 1'b1;
  localparam logic [CFG_W-1:0]     STEP_RESET       = 32'h0001_0000;
  localparam logic [CFG_W-1:0]     SCALE_RESET      = 32'h0001_0000;
  localparam logic [CHUNK_W-1:0]   RECIP3           = 18'd174763;

  localparam logic signed [RESULT_W-1:0] RES_MAX = {1'b0, {(RESULT_W-1){1'b1}}};
  localparam logic signed [RESULT_W-1:0] RES_MIN = {1'b1, {(RESULT_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_LONG  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SUM1,
    B_SUM2,
    B_MUL,
    B_LOAD,
    B_DIV,
    B_DONE
  } back_state_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } in_item_t;

  typedef struct packed {
    logic signed [RESULT_W-1:0] integral;
    status_t                    status;
  } out_item_t;

  typedef struct packed {
    logic signed [RESULT_W-1:0] wsum;
    logic [3:0][SAMPLE_W-1:0]   recent;
    status_t                    status;
    logic                       odd;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

### design/sif_front.sv
module sif_front #(
  parameter int MAX_SAMPLES = 65536
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sif_pkg::in_item_t in_item,
  output logic              push,
  output sif_pkg::job_t     job,
  input  sif_pkg::q_status_t q_st
);
  import sif_pkg::*;

  localparam int CNT_W = $clog2(MAX_SAMPLES + 2);
  localparam int SUM_W = $clog2(MAX_SAMPLES) + 36;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SAMPLES);
  localparam logic [CNT_W-1:0] TOP_CNT = CNT_W'(MAX_SAMPLES + 1);
  localparam logic [CNT_W-1:0] MIN_CNT = CNT_W'(MIN_RUN);

  logic [CNT_W-1:0]          count_r, count_nxt, run_count;
  logic signed [SUM_W-1:0]   wsum_r, wsum_nxt, run_wsum, sext, term;
  logic [3:0][SAMPLE_W-1:0]  recent_r, recent_nxt, run_recent;
  logic                      accept;

  always_comb begin
    accept     = in_valid && !in_stall;
    sext       = {{(SUM_W-SAMPLE_W){in_item.sample[SAMPLE_W-1]}}, in_item.sample};
    if (count_r == '0) begin
      term = sext;
    end else if (count_r[0]) begin
      term = sext <<< 2;
    end else begin
      term = sext <<< 1;
    end
    run_count  = count_r;
    run_wsum   = wsum_r;
    run_recent = recent_r;
    if (count_r < MAX_CNT) begin
      run_wsum   = wsum_r + term;
      run_recent = {recent_r[2:0], in_item.sample};
    end
    if (count_r <= MAX_CNT) begin
      run_count = count_r + 1'b1;
    end

    job.wsum   = {{(RESULT_W-SUM_W){run_wsum[SUM_W-1]}}, run_wsum};
    job.recent = run_recent;
    job.odd    = run_count[0];
    if (run_count < MIN_CNT) begin
      job.status = ST_SHORT;
    end else if (run_count > MAX_CNT) begin
      job.status = ST_LONG;
    end else begin
      job.status = ST_OK;
    end

    push       = accept && in_item.last;
    count_nxt  = count_r;
    wsum_nxt   = wsum_r;
    recent_nxt = recent_r;
    if (push) begin
      count_nxt  = '0;
      wsum_nxt   = '0;
      recent_nxt = '0;
    end else if (accept) begin
      count_nxt  = run_count;
      wsum_nxt   = run_wsum;
      recent_nxt = run_recent;
    end
  end

  assign in_stall = q_st.full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      wsum_r   <= '0;
      recent_r <= '0;
    end else begin
      count_r  <= count_nxt;
      wsum_r   <= wsum_nxt;
      recent_r <= recent_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= TOP_CNT)
    else $error("sample count beyond saturation");

  a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.last) |=> (count_r == '0 && wsum_r == '0))
    else $error("run not cleared after last sample");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_st.full)
    else $error("run pushed into full queue");

endmodule

### design/sif_queue.sv
module sif_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  sif_pkg::job_t      push_job,
  input  logic               pop,
  output sif_pkg::job_t      head,
  output sif_pkg::q_status_t q_st
);
  import sif_pkg::*;

  job_t                mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QFILL_W-1:0]  fill_r;
  logic                do_push, do_pop;

  always_comb begin
    q_st.empty = (fill_r == '0);
    q_st.full  = (fill_r == QFILL_W'(QDEPTH));
    do_push    = push && !q_st.full;
    do_pop     = pop && !q_st.empty;
    head       = mem_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

### design/sif_back.sv
module sif_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [sif_pkg::CFG_W-1:0]  spacing,
  input  logic [sif_pkg::CFG_W-1:0]  result_scale,
  input  sif_pkg::job_t              head,
  input  sif_pkg::q_status_t         q_st,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output sif_pkg::out_item_t         out_item
);
  import sif_pkg::*;

  back_state_t                   state_r, state_nxt;
  logic signed [RESULT_W-1:0]    t_r, t_nxt;
  logic                          neg_r, neg_nxt;
  logic [LIMBS-1:0][LIMB_W-1:0]  limb_r, limb_nxt;
  logic [LIMB_W-1:0]             carry_r, carry_nxt;
  logic [1:0]                    k_r, k_nxt;
  logic                          pass_r, pass_nxt;
  logic [QUO_W-1:0]              div_r, div_nxt;
  logic [1:0]                    rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0]          dcnt_r, dcnt_nxt;
  logic                          out_valid_r, out_valid_nxt;
  out_item_t                     out_item_r, out_item_nxt;

  logic                          out_free;
  logic signed [RESULT_W-1:0]    r0, r1, r2, r3, n;
  logic [RESULT_W-1:0]           mag;
  logic [LIMB_W-1:0]             factor;
  logic [2*LIMB_W-1:0]           prod;
  logic [CHUNK_W-1:0]            chunk, chunk_rem;
  logic [2*CHUNK_W-1:0]          recip;
  logic [DIV_BITS-1:0]           quo_dig;
  logic [RESULT_W-1:0]           qv;
  logic signed [RESULT_W-1:0]    result;

  always_comb begin
    out_free = !out_valid_r || !out_stall;
    r0 = {{(RESULT_W-SAMPLE_W){head.recent[0][SAMPLE_W-1]}}, head.recent[0]};
    r1 = {{(RESULT_W-SAMPLE_W){head.recent[1][SAMPLE_W-1]}}, head.recent[1]};
    r2 = {{(RESULT_W-SAMPLE_W){head.recent[2][SAMPLE_W-1]}}, head.recent[2]};
    r3 = {{(RESULT_W-SAMPLE_W){head.recent[3][SAMPLE_W-1]}}, head.recent[3]};

    n = t_r;
    if (!head.odd) begin
      n = t_r + (r1 <<< 3) + (r1 <<< 1) + r1 - (r0 <<< 4) - (r0 <<< 2) - (r0 <<< 1) - r0;
    end
    mag = n[RESULT_W-1] ? RESULT_W'(-n) : RESULT_W'(n);

    factor = pass_r ? result_scale : spacing;
    prod   = {{LIMB_W{1'b0}}, limb_r[k_r]} * {{LIMB_W{1'b0}}, factor}
           + {{LIMB_W{1'b0}}, carry_r};

    chunk     = {rem_r, div_r[QUO_W-1 -: DIV_BITS]};
    recip     = {{CHUNK_W{1'b0}}, chunk} * {{CHUNK_W{1'b0}}, RECIP3};
    quo_dig   = recip[RECIP_SH +: DIV_BITS];
    chunk_rem = chunk - {1'b0, quo_dig, 1'b0} - {2'b00, quo_dig};

    qv = div_r[RESULT_W-1:0];
    if (div_r[QUO_W-1:RESULT_W] != '0 || qv[RESULT_W-1]) begin
      result = neg_r ? RES_MIN : RES_MAX;
    end else begin
      result = neg_r ? -$signed(qv) : $signed(qv);
    end

    state_nxt     = state_r;
    t_nxt         = t_r;
    neg_nxt       = neg_r;
    limb_nxt      = limb_r;
    carry_nxt     = carry_r;
    k_nxt         = k_r;
    pass_nxt      = pass_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    dcnt_nxt      = dcnt_r;
    pop           = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;

    case (state_r)
      B_IDLE: begin
        if (!q_st.empty) begin
          if (head.status == ST_OK) begin
            state_nxt = B_SUM1;
          end else if (out_free) begin
            pop                   = 1'b1;
            out_valid_nxt         = 1'b1;
            out_item_nxt.integral = '0;
            out_item_nxt.status   = head.status;
          end
        end
      end
      B_SUM1: begin
        if (head.odd) begin
          t_nxt = (head.wsum <<< 3) - (r0 <<< 3);
        end else begin
          t_nxt = (head.wsum <<< 3) + r3 - (r2 <<< 2) - r2;
        end
        state_nxt = B_SUM2;
      end
      B_SUM2: begin
        pop       = 1'b1;
        neg_nxt   = n[RESULT_W-1];
        limb_nxt  = {{(2*LIMB_W){1'b0}}, mag};
        carry_nxt = '0;
        k_nxt     = '0;
        pass_nxt  = 1'b0;
        state_nxt = B_MUL;
      end
      B_MUL: begin
        limb_nxt[k_r] = prod[LIMB_W-1:0];
        carry_nxt     = prod[2*LIMB_W-1:LIMB_W];
        k_nxt         = k_r + 1'b1;
        if (k_r == 2'(LIMBS - 1)) begin
          carry_nxt = '0;
          if (!pass_r) begin
            pass_nxt = 1'b1;
          end else begin
            state_nxt = B_LOAD;
          end
        end
      end
      B_LOAD: begin
        div_nxt   = {limb_r[3], limb_r[2], limb_r[1]} >> PRE_SHIFT;
        rem_nxt   = '0;
        dcnt_nxt  = '0;
        state_nxt = B_DIV;
      end
      B_DIV: begin
        div_nxt  = {div_r[QUO_W-DIV_BITS-1:0], quo_dig};
        rem_nxt  = chunk_rem[1:0];
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = B_DONE;
        end
      end
      B_DONE: begin
        if (out_free) begin
          out_valid_nxt         = 1'b1;
          out_item_nxt.integral = result;
          out_item_nxt.status   = ST_OK;
          state_nxt             = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r        <= t_nxt;
    neg_r      <= neg_nxt;
    limb_r     <= limb_nxt;
    carry_r    <= carry_nxt;
    k_r        <= k_nxt;
    pass_r     <= pass_nxt;
    div_r      <= div_nxt;
    rem_r      <= rem_nxt;
    dcnt_r     <= dcnt_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_head_present: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_SUM1 || state_r == B_SUM2) |-> !q_st.empty)
    else $error("summing without a queued run");

  a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DONE && out_free) |=> (out_valid_r && state_r == B_IDLE))
    else $error("finished result not loaded");

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DIV) |-> (dcnt_r <= DIV_CNT_W'(DIV_STEPS - 1)))
    else $error("divide step count overrun");

endmodule

### design/simpson_stream_integrator.sv
// channel   direction  handshake              payload
// in_       request    in_valid / in_stall    in_item  (sample, last)
// out_      result     out_valid / out_stall  out_item (integral, status)
// cfg_      write      cfg_wr_en              cfg_index, cfg_data
//
// One sample per cycle while the run queue has room; a run closes on last.
// The back end takes a normal run through a pick-up step, two sum steps,
// eight limb steps on one 32x32 multiplier, a load, six steps dividing by
// three 16 bits a cycle, and a result load; a short or long run is answered
// from pick-up. Two closed runs may wait in the queue before in_stall rises.
// Synchronous reset clears run, queue and out_valid, and presets both registers.
module simpson_stream_integrator #(
  parameter int MAX_SAMPLES = 65536
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  sif_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output sif_pkg::out_item_t            out_item,
  input  logic                          cfg_wr_en,
  input  logic [sif_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sif_pkg::CFG_W-1:0]     cfg_data
);
  import sif_pkg::*;

  logic [CFG_W-1:0] spacing_r, result_scale_r;
  logic             push, pop;
  job_t             push_job, head;
  q_status_t        q_st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spacing_r      <= STEP_RESET;
      result_scale_r <= SCALE_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SPACING: begin
          spacing_r <= cfg_data;
        end
        REG_RESULT_SCALE: begin
          result_scale_r <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  sif_front #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .push     (push),
    .job      (push_job),
    .q_st     (q_st)
  );

  sif_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .q_st     (q_st)
  );

  sif_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .spacing      (spacing_r),
    .result_scale (result_scale_r),
    .head         (head),
    .q_st         (q_st),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_item     (out_item)
  );

endmodule

### test/sif_integral_checker.sv
module sif_integral_checker #(
  parameter int MAX_SAMPLES = 65536
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  sif_pkg::in_item_t             in_item,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  sif_pkg::out_item_t            out_item,
  input  logic                          cfg_wr_en,
  input  logic [sif_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sif_pkg::CFG_W-1:0]     cfg_data,
  output int                            mismatches,
  output int                            owed_count
);

  timeunit 1ns;
  timeprecision 1ps;

  import sif_pkg::*;

  logic [CFG_W-1:0] step_reg;
  logic [CFG_W-1:0] scale_reg;
  longint           run_sum;
  int               run_len;
  longint           hist [4];
  out_item_t        owed [$];

  initial mismatches = 0;
  initial owed_count = 0;

  function automatic logic signed [RESULT_W-1:0] scaled_integral(input longint n);
    logic [63:0]  mag;
    logic [127:0] prod;
    logic [95:0]  quo;
    mag  = (n < 0) ? 64'(-n) : 64'(n);
    prod = 128'(mag) * 128'(step_reg) * 128'(scale_reg);
    quo  = prod[127:32] / 96'd24;
    if (quo[95:64] != 0)
      return (n < 0) ? RES_MIN : RES_MAX;
    if (n < 0)
      return quo[63] ? RES_MIN : -$signed(quo[63:0]);
    return quo[63] ? RES_MAX : $signed(quo[63:0]);
  endfunction

  task automatic clear_run();
    run_sum = 0;
    run_len = 0;
    for (int k = 0; k < 4; k++)
      hist[k] = 0;
  endtask

  task automatic take_sample(input in_item_t it);
    longint    s;
    longint    wgt;
    longint    n;
    longint    s13;
    longint    s38;
    out_item_t want;
    s = longint'($signed(it.sample));
    if (run_len < MAX_SAMPLES) begin
      wgt = (run_len == 0) ? 1 : ((run_len % 2 == 1) ? 4 : 2);
      run_sum += wgt * s;
      hist[3] = hist[2];
      hist[2] = hist[1];
      hist[1] = hist[0];
      hist[0] = s;
    end
    if (run_len <= MAX_SAMPLES)
      run_len++;
    if (it.last) begin
      want.integral = '0;
      if (run_len < MIN_RUN) begin
        want.status = ST_SHORT;
      end else if (run_len > MAX_SAMPLES) begin
        want.status = ST_LONG;
      end else begin
        want.status = ST_OK;
        if (run_len % 2 == 1) begin
          n = 8 * (run_sum - hist[0]);
        end else begin
          s13 = run_sum - 4 * hist[0] - 2 * hist[1] - 4 * hist[2] - hist[3];
          s38 = hist[3] + 3 * hist[2] + 3 * hist[1] + hist[0];
          n   = 8 * s13 + 9 * s38;
        end
        want.integral = scaled_integral(n);
      end
      owed.push_back(want);
      clear_run();
    end
  endtask

  task automatic match_result(input out_item_t got);
    out_item_t want;
    if (owed.size() == 0) begin
      $display("%0t unexpected result: expected none, actual integral %0d status %0d",
               $time, $signed(got.integral), got.status);
      mismatches++;
    end else begin
      want = owed.pop_front();
      if (got.integral !== want.integral) begin
        $display("%0t integral mismatch: expected %0d, actual %0d",
                 $time, $signed(want.integral), $signed(got.integral));
        mismatches++;
      end
      if (got.status !== want.status) begin
        $display("%0t status mismatch: expected %0d, actual %0d",
                 $time, want.status, got.status);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      step_reg  = STEP_RESET;
      scale_reg = SCALE_RESET;
      clear_run();
      owed.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == REG_SPACING)
          step_reg = cfg_data;
        else if (cfg_index == REG_RESULT_SCALE)
          scale_reg = cfg_data;
      end
      if (out_valid && !out_stall)
        match_result(out_item);
      if (in_valid && !in_stall)
        take_sample(in_item);
    end
    owed_count = owed.size();
  end

endmodule

### test/tb_simpson_stream_integrator.sv
module tb_simpson_stream_integrator;

  timeunit 1ns;
  timeprecision 1ps;

  import sif_pkg::*;

  localparam int RUN_CAP    = 65536;
  localparam int CYCLE_CAP  = 1000000;
  localparam int PHASE_LEN  = 140;
  localparam int SETTLE_CYC = 60;

  localparam logic [SAMPLE_W-1:0] SAT_HI = 32'h7fff_ffff;
  localparam logic [SAMPLE_W-1:0] SAT_LO = 32'h8000_0000;

  localparam logic [CFG_W-1:0] STEP_SET [7] = '{
    32'h0001_0000, 32'h0000_0001, 32'hffff_ffff, 32'h0000_0001,
    32'hffff_ffff, 32'h0000_0000, 32'h0003_0000
  };
  localparam logic [CFG_W-1:0] SCALE_SET [7] = '{
    32'h0001_0000, 32'h0000_0000, 32'hffff_ffff, 32'h0000_0001,
    32'h0000_0001, 32'h0001_0000, 32'h0000_8000
  };

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_item   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_item;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  int          mismatches;
  int          owed_count;
  int          cycles    = 0;
  logic        calm      = 1'b0;
  logic        res_taken = 1'b0;
  int unsigned res_hold  = 5;

  always #2 clk = ~clk;

  simpson_stream_integrator #(
    .MAX_SAMPLES(RUN_CAP)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sif_integral_checker #(
    .MAX_SAMPLES(RUN_CAP)
  ) integral_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .owed_count (owed_count)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("simpson_stream_integrator verification failed");
      $finish;
    end
  end

  always @(posedge clk)
    res_taken <= rst_n && out_valid && !out_stall;

  // after each taken result, stall the result side for a randomly drawn hold, none in calm runs
  always @(negedge clk) begin
    if (res_taken)
      res_hold = calm ? 0 : $urandom_range(0, 15);
    if (res_hold != 0) begin
      out_stall <= 1'b1;
      res_hold--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return SAT_HI;
      1: return SAT_LO;
      2: return '0;
      3, 4: return SAMPLE_W'(int'($urandom_range(0, 131072)) - 65536);
      default: return $urandom();
    endcase
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12)
      return $urandom_range(1, 8);
    if (r < 18)
      return $urandom_range(9, 40);
    return $urandom_range(41, 200);
  endfunction

  task automatic push_sample(input logic [SAMPLE_W-1:0] s, input logic fin);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{sample: s, last: fin};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_run(input int len);
    calm = (len > 1000) || ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++)
      push_sample(pick_sample(), i == len - 1);
  endtask

  // drop valid and wait for every owed result before touching the registers
  task automatic settle();
    in_valid <= 1'b0;
    while (owed_count != 0)
      @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic set_gains(input logic [CFG_W-1:0] step, input logic [CFG_W-1:0] scale);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_SPACING;
    cfg_data  <= step;
    @(negedge clk);
    cfg_index <= REG_RESULT_SCALE;
    cfg_data  <= scale;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int sent;
    int len;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    push_sample(SAT_HI, 1'b1);
    push_sample(SAT_LO, 1'b0);
    push_sample(SAT_LO, 1'b1);
    repeat (2) push_sample(SAT_HI, 1'b0);
    push_sample(SAT_HI, 1'b1);
    repeat (3) push_sample(SAT_LO, 1'b0);
    push_sample(SAT_LO, 1'b1);
    send_run(5);
    send_run(6);
    settle();

    set_gains(32'hffff_ffff, 32'hffff_ffff);
    repeat (2) push_sample(SAT_HI, 1'b0);
    push_sample(SAT_HI, 1'b1);
    repeat (3) push_sample(SAT_LO, 1'b0);
    push_sample(SAT_LO, 1'b1);
    settle();

    for (int p = 0; p < 9; p++) begin
      if (p < 7)
        set_gains(STEP_SET[p], SCALE_SET[p]);
      else
        set_gains($urandom(), $urandom());
      sent = 0;
      while (sent < PHASE_LEN) begin
        len = pick_len();
        send_run(len);
        sent += len;
      end
      settle();
    end

    set_gains(STEP_RESET, SCALE_RESET);
    send_run(3);
    settle();
    repeat (40) @(negedge clk);

    if (mismatches == 0 && owed_count == 0)
      $display("simpson_stream_integrator verification clean");
    else
      $display("simpson_stream_integrator verification failed");
    $finish;
  end

endmodule
